### design/rmffp_pkg.sv
// Shared types and constants for the rate-monotonic first-fit partitioner.
`timescale 1ns / 1ps
`default_nettype none
package rmffp_pkg;

  localparam int MAX_PROCS_DEF          = 16;
  localparam int MAX_TASKS_PER_PROC_DEF = 32;
  localparam int FRAC_BITS_DEF          = 16;

  localparam int TICK_W   = 16;  // period and wcet width
  localparam int LIMIT_W  = 5;   // processor_limit width
  localparam int INDEX_W  = 4;   // processor_index width
  localparam int USED_W   = 5;   // processors_used width

  // Result status codes
  typedef enum logic [1:0] {
    ST_PLACED = 2'd0,
    ST_BAD    = 2'd1,
    ST_NOPROC = 2'd2
  } status_t;

  // Datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_IDLE,
    OP_LOAD,
    OP_DIV_STEP,
    OP_SCAN_INIT,
    OP_READ,
    OP_NEXT,
    OP_TAKE_HIT,
    OP_TAKE_NEW,
    OP_SUM,
    OP_X_INIT,
    OP_MUL,
    OP_Q_START,
    OP_WRITE,
    OP_RESULT
  } op_t;

  typedef struct packed {
    op_t     op;
    status_t status;
  } ctrl_cmd_t;

  typedef struct packed {
    logic per_zero;
    logic div_busy;
    logic u_bad;
    logic scan_end;
    logic procs_full;
    logic hit;
    logic mul_done;
  } dp_sts_t;

endpackage
`default_nettype wire

### design/rm_first_fit_partitioner.sv
// Top level of the rate-monotonic first-fit partitioner.
`timescale 1ns / 1ps
`default_nettype none
// Takes one periodic task per request (period, wcet, new_set), assumed in
// rate-monotonic order, and places it on the first processor whose cached
// IP bound 2*(1+U/n)^-n - 1 admits its utilization u = wcet/period (Q.16),
// or else opens the next empty processor. One request is worked at a time.
// NW = max(16+FRAC_BITS, 2*FRAC_BITS+2) is the bit count of the shared
// restoring divider (one quotient bit per cycle, used three times per placed
// task). The processor scan reads the table through one read port, and the
// bound update does one multiply per cycle, at most one for each task of the
// chosen processor. A new request is taken while the previous result still
// waits on the output register.
// The processor table needs no clearing: entries at or above the in-use
// count read as empty, and new_set simply resets that count.
module rm_first_fit_partitioner #(
  parameter int MAX_PROCS          = rmffp_pkg::MAX_PROCS_DEF,
  parameter int MAX_TASKS_PER_PROC = rmffp_pkg::MAX_TASKS_PER_PROC_DEF,
  parameter int FRAC_BITS          = rmffp_pkg::FRAC_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [rmffp_pkg::TICK_W-1:0]      in_period,
  input  wire logic [rmffp_pkg::TICK_W-1:0]      in_wcet,
  input  wire logic                              in_new_set,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic      [rmffp_pkg::INDEX_W-1:0]     out_processor_index,
  output logic      [rmffp_pkg::USED_W-1:0]      out_processors_used,
  output logic                                   out_schedulable,
  output logic      [1:0]                        out_status,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [rmffp_pkg::LIMIT_W-1:0]     cfg_processor_limit
);

  rmffp_pkg::ctrl_cmd_t cmd;
  rmffp_pkg::dp_sts_t   sts;

  // Register writes are always taken.
  assign cfg_ready = 1'b1;

  rmffp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  rmffp_datapath #(
    .MAX_PROCS          (MAX_PROCS),
    .MAX_TASKS_PER_PROC (MAX_TASKS_PER_PROC),
    .FRAC_BITS          (FRAC_BITS)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .in_period           (in_period),
    .in_wcet             (in_wcet),
    .in_new_set          (in_new_set),
    .cfg_we              (cfg_valid && cfg_ready),
    .cfg_limit           (cfg_processor_limit),
    .out_processor_index (out_processor_index),
    .out_processors_used (out_processors_used),
    .out_schedulable     (out_schedulable),
    .out_status          (out_status)
  );

endmodule
`default_nettype wire

### design/rmffp_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module rmffp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic                                  re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

### design/rmffp_datapath.sv
// Datapath: shared divider, bound multiplier, processor table and result registers.
`timescale 1ns / 1ps
`default_nettype none
module rmffp_datapath #(
  parameter int MAX_PROCS          = rmffp_pkg::MAX_PROCS_DEF,
  parameter int MAX_TASKS_PER_PROC = rmffp_pkg::MAX_TASKS_PER_PROC_DEF,
  parameter int FRAC_BITS          = rmffp_pkg::FRAC_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire rmffp_pkg::ctrl_cmd_t              cmd,
  output rmffp_pkg::dp_sts_t                     sts,
  input  wire logic [rmffp_pkg::TICK_W-1:0]      in_period,
  input  wire logic [rmffp_pkg::TICK_W-1:0]      in_wcet,
  input  wire logic                              in_new_set,
  input  wire logic                              cfg_we,
  input  wire logic [rmffp_pkg::LIMIT_W-1:0]     cfg_limit,
  output logic      [rmffp_pkg::INDEX_W-1:0]     out_processor_index,
  output logic      [rmffp_pkg::USED_W-1:0]      out_processors_used,
  output logic                                   out_schedulable,
  output logic      [1:0]                        out_status
);

  localparam int F   = FRAC_BITS;
  localparam int TW  = rmffp_pkg::TICK_W;
  localparam int UW  = F + 2;                 // summed utilization
  localparam int BW  = F + 1;                 // bound, single utilization
  localparam int PW  = F + 2;                 // running power
  localparam int XW  = F + 3;                 // base 1 + U/n
  localparam int MW  = PW + XW;               // product
  localparam int CW  = $clog2(MAX_TASKS_PER_PROC + 1);
  localparam int IW  = MAX_PROCS > 1 ? $clog2(MAX_PROCS) : 1;
  localparam int NCW = $clog2(MAX_PROCS + 1);
  localparam int NW  = (TW + F) > (2 * F + 2) ? (TW + F) : (2 * F + 2);
  localparam int DW  = TW > (F + 2) ? TW : (F + 2);
  localparam int DCW = $clog2(NW + 1);
  localparam int EW  = UW + CW + BW;
  localparam int LW  = rmffp_pkg::LIMIT_W;

  localparam logic [NW-1:0] ONE_N      = NW'(1) << F;
  localparam logic [NW-1:0] Q_NUM_BASE = NW'(1) << (2 * F + 1);
  localparam logic [BW-1:0] ONE_B      = BW'(1) << F;
  localparam logic [XW-1:0] ONE_X      = XW'(1) << F;
  localparam logic [PW-1:0] ONE_P      = PW'(1) << F;
  localparam logic [PW-1:0] TWO_P      = PW'(1) << (F + 1);
  localparam logic [MW-1:0] HALF_M     = MW'(1) << (F - 1);
  localparam logic [UW-1:0] U_MAX      = '1;

  // Divider
  logic [NW-1:0]  div_num_r;
  logic [DW-1:0]  div_den_r;
  logic [DW:0]    div_rem_r;
  logic [DCW-1:0] div_cnt_r;
  logic           div_ld;
  logic [NW-1:0]  div_num_in;
  logic [DW-1:0]  div_den_in;
  logic [DW:0]    rem_sh;
  logic           rem_ge;
  logic [DW:0]    rem_nxt;

  // Task and processor registers
  logic           per_zero_r;
  logic [BW-1:0]  u_r;
  logic [NCW-1:0] used_r;
  logic [NCW-1:0] scan_i_r;
  logic [IW-1:0]  idx_r;
  logic [UW-1:0]  util_r;
  logic [CW-1:0]  tcnt_r;
  logic [XW-1:0]  x_r;
  logic [PW-1:0]  p_r;
  logic [CW-1:0]  k_r;
  logic [LW-1:0]  limit_r;

  logic [UW:0]    sum_full;
  logic [UW-1:0]  sum_sat;
  logic [CW-1:0]  cnt_inc;
  logic [MW-1:0]  prod;
  logic [MW-1:0]  prod_rnd;
  logic [MW-F-1:0] prod_sh;
  logic [PW-1:0]  p_nxt;
  logic [NW-1:0]  q_minus;
  logic [BW-1:0]  bound_val;

  logic           ram_we;
  logic           ram_re;
  logic [EW-1:0]  ram_wdata;
  logic [EW-1:0]  ram_rdata;
  logic [UW-1:0]  r_util;
  logic [CW-1:0]  r_cnt;
  logic [BW-1:0]  r_bound;

  logic [IW+rmffp_pkg::INDEX_W-1:0] idx_wide;
  logic [NCW+rmffp_pkg::USED_W-1:0] used_wide;
  logic [NCW+LW-1:0]                used_cmp;
  logic [NCW+LW-1:0]                limit_cmp;

  logic [rmffp_pkg::INDEX_W-1:0] out_idx_r;
  logic [rmffp_pkg::USED_W-1:0]  out_used_r;
  logic                          out_sched_r;
  logic [1:0]                    out_status_r;

  assign rem_sh  = {div_rem_r[DW-1:0], div_num_r[NW-1]};
  assign rem_ge  = rem_sh >= {1'b0, div_den_r};
  assign rem_nxt = rem_ge ? (rem_sh - {1'b0, div_den_r}) : rem_sh;

  assign sum_full = {1'b0, util_r} + (UW + 1)'(u_r);
  assign sum_sat  = sum_full[UW] ? U_MAX : sum_full[UW-1:0];
  assign cnt_inc  = tcnt_r + CW'(1);

  assign prod     = MW'(p_r) * MW'(x_r);
  assign prod_rnd = prod + HALF_M;
  assign prod_sh  = prod_rnd[MW-1:F];
  assign p_nxt    = (prod_sh >= (MW-F)'(TWO_P)) ? TWO_P : prod_sh[PW-1:0];

  // q - 1.0, clamped to [0, 1.0]
  assign q_minus   = div_num_r - ONE_N;
  assign bound_val = (div_num_r <= ONE_N) ? '0 :
                     ((q_minus > ONE_N) ? ONE_B : q_minus[BW-1:0]);

  always_comb begin
    div_ld     = 1'b0;
    div_num_in = '0;
    div_den_in = '0;
    case (cmd.op)
      rmffp_pkg::OP_LOAD: begin
        div_ld                   = 1'b1;
        div_num_in[TW+F-1:0]     = {in_wcet, {F{1'b0}}};
        div_den_in[TW-1:0]       = in_period;
      end
      rmffp_pkg::OP_SUM: begin
        div_ld                   = 1'b1;
        div_num_in[UW-1:0]       = sum_sat;
        div_den_in[CW-1:0]       = cnt_inc;
      end
      rmffp_pkg::OP_Q_START: begin
        div_ld                   = 1'b1;
        div_num_in               = Q_NUM_BASE + NW'(p_r >> 1);
        div_den_in[PW-1:0]       = p_r;
      end
      default: begin
        div_ld = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_cnt_r <= '0;
      used_r    <= '0;
      limit_r   <= '0;
    end else begin
      if (cfg_we) begin
        limit_r <= cfg_limit;
      end
      if (div_ld) begin
        div_cnt_r <= DCW'(NW);
      end else if (cmd.op == rmffp_pkg::OP_DIV_STEP) begin
        div_cnt_r <= div_cnt_r - DCW'(1);
      end
      if (cmd.op == rmffp_pkg::OP_LOAD && in_new_set) begin
        used_r <= '0;
      end else if (cmd.op == rmffp_pkg::OP_TAKE_NEW) begin
        used_r <= used_r + NCW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (div_ld) begin
      div_num_r <= div_num_in;
      div_den_r <= div_den_in;
      div_rem_r <= '0;
    end else if (cmd.op == rmffp_pkg::OP_DIV_STEP) begin
      div_num_r <= {div_num_r[NW-2:0], rem_ge};
      div_rem_r <= rem_nxt;
    end
    case (cmd.op)
      rmffp_pkg::OP_LOAD: begin
        per_zero_r <= (in_period == '0);
      end
      rmffp_pkg::OP_SCAN_INIT: begin
        u_r      <= div_num_r[BW-1:0];
        scan_i_r <= '0;
      end
      rmffp_pkg::OP_NEXT: begin
        scan_i_r <= scan_i_r + NCW'(1);
      end
      rmffp_pkg::OP_TAKE_HIT: begin
        util_r <= r_util;
        tcnt_r <= r_cnt;
        idx_r  <= scan_i_r[IW-1:0];
      end
      rmffp_pkg::OP_TAKE_NEW: begin
        util_r <= '0;
        tcnt_r <= '0;
        idx_r  <= used_r[IW-1:0];
      end
      rmffp_pkg::OP_SUM: begin
        util_r <= sum_sat;
        tcnt_r <= cnt_inc;
      end
      rmffp_pkg::OP_X_INIT: begin
        x_r <= XW'(div_num_r[UW-1:0]) + ONE_X;
        p_r <= ONE_P;
        k_r <= '0;
      end
      rmffp_pkg::OP_MUL: begin
        p_r <= p_nxt;
        k_r <= k_r + CW'(1);
      end
      rmffp_pkg::OP_RESULT: begin
        out_idx_r    <= (cmd.status == rmffp_pkg::ST_PLACED) ?
                        idx_wide[rmffp_pkg::INDEX_W-1:0] : '0;
        out_used_r   <= used_wide[rmffp_pkg::USED_W-1:0];
        out_sched_r  <= (limit_r == '0) || (used_cmp <= limit_cmp);
        out_status_r <= cmd.status;
      end
      default: begin
        per_zero_r <= per_zero_r;
      end
    endcase
  end

  assign idx_wide  = {{rmffp_pkg::INDEX_W{1'b0}}, idx_r};
  assign used_wide = {{rmffp_pkg::USED_W{1'b0}}, used_r};
  assign used_cmp  = {{LW{1'b0}}, used_r};
  assign limit_cmp = {{NCW{1'b0}}, limit_r};

  // Processor table: {utilization, task count, cached bound}
  assign ram_we    = (cmd.op == rmffp_pkg::OP_WRITE);
  assign ram_re    = (cmd.op == rmffp_pkg::OP_READ);
  assign ram_wdata = {util_r, tcnt_r, bound_val};
  assign {r_util, r_cnt, r_bound} = ram_rdata;

  rmffp_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_PROCS)
  ) u_proc_tbl (
    .clk   (clk),
    .we    (ram_we),
    .waddr (idx_r),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (scan_i_r[IW-1:0]),
    .rdata (ram_rdata)
  );

  assign sts.per_zero   = per_zero_r;
  assign sts.div_busy   = (div_cnt_r != '0);
  assign sts.u_bad      = (div_num_r > ONE_N);
  assign sts.scan_end   = (scan_i_r == used_r);
  assign sts.procs_full = (used_r == NCW'(MAX_PROCS));
  assign sts.hit        = (r_cnt < CW'(MAX_TASKS_PER_PROC)) && (u_r <= r_bound);
  assign sts.mul_done   = (k_r == tcnt_r) || (p_r == TWO_P);

  assign out_processor_index = out_idx_r;
  assign out_processors_used = out_used_r;
  assign out_schedulable     = out_sched_r;
  assign out_status          = out_status_r;

endmodule
`default_nettype wire

### design/rmffp_ctrl.sv
// Controller: sequences one request through divide, scan, bound update and result.
`timescale 1ns / 1ps
`default_nettype none
module rmffp_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  input  wire rmffp_pkg::dp_sts_t   sts,
  output rmffp_pkg::ctrl_cmd_t      cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIVU,
    S_CHKU,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_SUM,
    S_DIVX,
    S_MUL,
    S_DIVQ,
    S_RES
  } state_t;

  state_t              state_r, state_nxt;
  rmffp_pkg::status_t  code_r, code_nxt;
  logic                out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    code_nxt      = code_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd.op        = rmffp_pkg::OP_IDLE;
    cmd.status    = code_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = rmffp_pkg::OP_LOAD;
          state_nxt = S_DIVU;
        end
      end
      S_DIVU: begin
        if (sts.per_zero) begin
          code_nxt  = rmffp_pkg::ST_BAD;
          state_nxt = S_RES;
        end else if (sts.div_busy) begin
          cmd.op = rmffp_pkg::OP_DIV_STEP;
        end else begin
          state_nxt = S_CHKU;
        end
      end
      S_CHKU: begin
        if (sts.u_bad) begin
          code_nxt  = rmffp_pkg::ST_BAD;
          state_nxt = S_RES;
        end else begin
          cmd.op    = rmffp_pkg::OP_SCAN_INIT;
          state_nxt = S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        if (sts.scan_end) begin
          if (sts.procs_full) begin
            code_nxt  = rmffp_pkg::ST_NOPROC;
            state_nxt = S_RES;
          end else begin
            cmd.op    = rmffp_pkg::OP_TAKE_NEW;
            state_nxt = S_SUM;
          end
        end else begin
          cmd.op    = rmffp_pkg::OP_READ;
          state_nxt = S_SCAN_CMP;
        end
      end
      S_SCAN_CMP: begin
        if (sts.hit) begin
          cmd.op    = rmffp_pkg::OP_TAKE_HIT;
          state_nxt = S_SUM;
        end else begin
          cmd.op    = rmffp_pkg::OP_NEXT;
          state_nxt = S_SCAN_RD;
        end
      end
      S_SUM: begin
        cmd.op    = rmffp_pkg::OP_SUM;
        state_nxt = S_DIVX;
      end
      S_DIVX: begin
        if (sts.div_busy) begin
          cmd.op = rmffp_pkg::OP_DIV_STEP;
        end else begin
          cmd.op    = rmffp_pkg::OP_X_INIT;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        if (sts.mul_done) begin
          cmd.op    = rmffp_pkg::OP_Q_START;
          state_nxt = S_DIVQ;
        end else begin
          cmd.op = rmffp_pkg::OP_MUL;
        end
      end
      S_DIVQ: begin
        if (sts.div_busy) begin
          cmd.op = rmffp_pkg::OP_DIV_STEP;
        end else begin
          cmd.op    = rmffp_pkg::OP_WRITE;
          code_nxt  = rmffp_pkg::ST_PLACED;
          state_nxt = S_RES;
        end
      end
      S_RES: begin
        if (!out_valid_r || out_ready) begin
          cmd.op        = rmffp_pkg::OP_RESULT;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      code_r      <= rmffp_pkg::ST_PLACED;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      code_r      <= code_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

### design/rmffp_checker.sv
// Port-level checker for the partitioner and its bind.
`timescale 1ns / 1ps
`default_nettype none
module rmffp_checker #(
  parameter int MAX_PROCS = rmffp_pkg::MAX_PROCS_DEF
) (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           in_valid,
  input wire logic                           in_ready,
  input wire logic                           out_valid,
  input wire logic                           out_ready,
  input wire logic [rmffp_pkg::INDEX_W-1:0]  out_processor_index,
  input wire logic [rmffp_pkg::USED_W-1:0]   out_processors_used,
  input wire logic [1:0]                     out_status
);

  localparam logic [rmffp_pkg::USED_W-1:0] FULL_USED = rmffp_pkg::USED_W'(MAX_PROCS);

  // A pending result holds until taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_processor_index)
      && $stable(out_status))
    else $error("result dropped or changed while stalled");

  // One request in flight: no back-to-back accept.
  a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second request accepted while busy");

  // Rejected tasks report processor zero.
  a_rej_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != rmffp_pkg::ST_PLACED |-> out_processor_index == '0)
    else $error("nonzero index on rejected task");

  // Running out of processors only happens with all of them in use.
  a_noproc_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == rmffp_pkg::ST_NOPROC |-> out_processors_used == FULL_USED)
    else $error("no-processor status with free processors");

endmodule

bind rm_first_fit_partitioner rmffp_checker #(
  .MAX_PROCS (MAX_PROCS)
) u_rmffp_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_valid),
  .in_ready            (in_ready),
  .out_valid           (out_valid),
  .out_ready           (out_ready),
  .out_processor_index (out_processor_index),
  .out_processors_used (out_processors_used),
  .out_status          (out_status)
);
`default_nettype wire

### tb/sv/tb_top.sv
// Self-checking testbench for the rate-monotonic first-fit partitioner.
`timescale 1ns / 1ps
module tb_top;

  localparam int NPROC    = 16;
  localparam int TASK_CAP = 32;
  localparam int FB       = 16;
  localparam longint ONE  = 64'd1 << FB;
  localparam longint TWO  = 64'd2 << FB;
  localparam longint HALF = 64'd1 << (FB - 1);
  localparam longint USAT = (64'd4 << FB) - 1;
  localparam int SETTLE   = 400;  // cycles waited after the results drain

  typedef struct packed {
    logic [15:0] period;
    logic [15:0] wcet;
    logic        new_set;
  } task_req_t;

  typedef struct packed {
    logic [3:0]          index;
    logic [4:0]          used;
    logic                sched;
    rmffp_pkg::status_t  status;
  } placement_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [15:0] in_period = '0;
  logic [15:0] in_wcet = '0;
  logic in_new_set = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [3:0] out_processor_index;
  logic [4:0] out_processors_used;
  logic out_schedulable;
  logic [1:0] out_status;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [4:0] cfg_processor_limit = '0;

  rm_first_fit_partitioner i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_period(in_period), .in_wcet(in_wcet), .in_new_set(in_new_set),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_processor_index(out_processor_index),
    .out_processors_used(out_processors_used),
    .out_schedulable(out_schedulable), .out_status(out_status),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_processor_limit(cfg_processor_limit)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the processor table and the limit register
  longint     util_q[NPROC];
  int         task_cnt[NPROC];
  longint     bound_q[NPROC];
  int         procs_open;
  logic [4:0] limit_shadow = '0;

  task_req_t  pending_reqs[$];
  placement_t expected_q[$];
  int         mismatches = 0;
  bit         sender_hold = 0;   // pause the sender until results drain
  int         stall_reqs = 0;    // bumped to ask for a long receiver hold-off
  int         stall_seen = 0;
  int         stall_left = 0;    // long receiver hold-off, counted in cycles

  function automatic void clear_table();
    for (int i = 0; i < NPROC; i++) begin
      util_q[i] = 0;
      task_cnt[i] = 0;
      bound_q[i] = ONE;
    end
    procs_open = 0;
  endfunction

  // IP admission bound 2*(1+U/n)^-n - 1 in fixed point
  function automatic longint ip_admit(longint total, int n);
    longint x, p, q;
    if (n == 0) return ONE;
    x = ONE + total / n;
    p = ONE;
    for (int k = 0; k < n; k++) begin
      p = (p * x + HALF) >> FB;
      if (p >= TWO) begin
        p = TWO;
        break;
      end
    end
    q = ((TWO << FB) + p / 2) / p;
    if (q <= ONE) return 0;
    q -= ONE;
    return (q > ONE) ? ONE : q;
  endfunction

  // Advance the shadow table by one request and return the placement
  function automatic placement_t place_task(task_req_t r);
    placement_t res;
    longint u, s;
    int idx;
    bit hit;
    idx = 0;
    hit = 0;
    res.status = rmffp_pkg::ST_PLACED;
    if (r.new_set) clear_table();
    if (r.period == 0) begin
      res.status = rmffp_pkg::ST_BAD;
    end else begin
      u = (longint'(r.wcet) << FB) / r.period;
      if (u > ONE) begin
        res.status = rmffp_pkg::ST_BAD;
      end else begin
        for (int i = 0; i < procs_open; i++)
          if (!hit && task_cnt[i] < TASK_CAP && u <= bound_q[i]) begin
            idx = i;
            hit = 1;
          end
        if (!hit && procs_open < NPROC) begin
          idx = procs_open;
          procs_open++;
          hit = 1;
        end
        if (hit) begin
          s = util_q[idx] + u;
          util_q[idx] = (s > USAT) ? USAT : s;
          task_cnt[idx]++;
          bound_q[idx] = ip_admit(util_q[idx], task_cnt[idx]);
        end else begin
          res.status = rmffp_pkg::ST_NOPROC;
          idx = 0;
        end
      end
    end
    res.index = idx[3:0];
    res.used = procs_open[4:0];
    res.sched = (limit_shadow == 0) || (procs_open <= limit_shadow);
    return res;
  endfunction

  // Driver: bursts of requests with random gaps
  int burst_left, gap_left;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
      clear_table();
    end else if (!in_valid || in_ready) begin
      if (in_valid && in_ready)
        expected_q.push_back(place_task('{in_period, in_wcet, in_new_set}));
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (pending_reqs.size() > 0 && !sender_hold) begin
        task_req_t r;
        r = pending_reqs.pop_front();
        in_valid <= 1'b1;
        in_period <= r.period;
        in_wcet <= r.wcet;
        in_new_set <= r.new_set;
        if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 40);
          if ($urandom_range(0, 3) == 0) gap_left <= $urandom_range(1, 60);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Long hold-off counter, loaded on request from the stimulus
  always @(posedge clk) begin
    if (stall_seen != stall_reqs) begin
      stall_seen <= stall_reqs;
      stall_left <= 600;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end
  end

  // Receiver stall pattern plus the long hold-off
  int rx_phase = 0;
  always @(posedge clk) begin
    rx_phase <= rx_phase + 1;
    if (stall_left > 0) begin
      out_ready <= 1'b0;
    end else if (rx_phase[9]) begin
      out_ready <= 1'b1;  // stretch with no stalls
    end else begin
      out_ready <= ($urandom_range(0, 3) != 0);
    end
  end

  // Monitor: compare each result with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      placement_t exp_r;
      placement_t got;
      got = '{out_processor_index, out_processors_used, out_schedulable,
              rmffp_pkg::status_t'(out_status)};
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected result %p", got);
      end else begin
        exp_r = expected_q.pop_front();
        if (got !== exp_r) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: expected %p, got %p", exp_r, got);
        end
      end
    end
  end

  task automatic add_req(int per, int wc, bit ns);
    pending_reqs.push_back('{per[15:0], wc[15:0], ns});
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() > 0 || in_valid || expected_q.size() > 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_limit(logic [4:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_processor_limit <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    limit_shadow = v;
  endtask

  // Random task: mostly modest utilization, some heavy or malformed
  task automatic add_random(bit ns);
    int per, wc;
    case ($urandom_range(0, 9))
      0: begin per = $urandom_range(0, 65535); wc = $urandom_range(0, 65535); end
      1: begin per = $urandom_range(1, 65535); wc = per; end
      2: begin per = $urandom_range(1, 65535); wc = 0; end
      3: begin per = $urandom_range(1, 200); wc = $urandom_range(0, 200); end
      default: begin
        per = $urandom_range(1000, 65535);
        wc = $urandom_range(0, per / $urandom_range(2, 12));
      end
    endcase
    add_req(per, wc, ns);
  endtask

  initial begin
    int phase;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: field extremes, bad period, u over one, u exactly one, zero u
    add_req(0, 0, 0);
    add_req(0, 65535, 1);
    add_req(65535, 65535, 0);
    add_req(1, 2, 0);
    add_req(65535, 0, 0);
    add_req(65535, 65534, 0);
    add_req(2, 1, 0);
    add_req(3, 1, 0);
    add_req(3, 1, 0);
    add_req(0, 5, 1);       // new set clears even though rejected
    add_req(1, 0, 0);
    // Fill one processor past its task cap with zero-utilization tasks
    for (int i = 0; i < 34; i++) add_req(100, 0, 0);
    wait_drained();

    // No processor left: full tasks open all processors, then one more
    write_limit(5'd16);
    add_req(1, 1, 1);
    for (int i = 0; i < 17; i++) add_req(7, 7, 0);
    add_req(10, 1, 0);
    wait_drained();

    // Random phases with different limits, extremes among them
    for (phase = 0; phase < 8; phase++) begin
      case (phase)
        0: write_limit(5'd0);
        1: write_limit(5'd1);
        2: write_limit(5'd31);
        3: write_limit(5'd16);
        default: write_limit(5'($urandom_range(0, 31)));
      endcase
      if (phase == 2) begin
        stall_reqs++;  // receiver holds off while the sender keeps going
        repeat (2) @(posedge clk);
      end
      for (int i = 0; i < 160; i++)
        add_random(($urandom_range(0, 40) == 0) || i == 0);
      if (phase == 4) begin
        while (pending_reqs.size() > 80) @(posedge clk);
        sender_hold = 1;
        while (expected_q.size() > 0) @(posedge clk);
        sender_hold = 0;
      end
      wait_drained();
    end
    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  initial begin
    #20ms;
    $display("Mismatches found");
    $finish;
  end
endmodule
